/* sv/sdd_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the diamond-difference cell solver
package sdd_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int PHI_W  = 32;   // result and flux width
    localparam int COS_W  = 17;
    localparam int FAC_W  = 31;
    localparam int QL_W   = 64;   // numerator, exact
    localparam int DL_W   = 34;   // denominator, exact
    localparam int FACE_W = 34;   // outgoing face before saturation
    localparam int CFG_IDX_W = 2;

    localparam logic [PHI_W-1:0] S32_MAX = 32'h7fff_ffff;
    localparam logic [PHI_W-1:0] S32_MIN = 32'h8000_0000;
    localparam logic [FAC_W-1:0] FACTOR_RST = 31'd131072;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIXUP    = 2'd0,
        CFG_X_FACTOR = 2'd1,
        CFG_Y_FACTOR = 2'd2,
        CFG_Z_FACTOR = 2'd3
    } t_cfg_idx;

    // working context of one cell as it travels down the pipe
    typedef struct packed {
        logic                       need_div;
        logic                       div;
        logic                       fixen;
        logic [2:0]                 fixed;
        logic [QL_W-1:0]            ql;
        logic [DL_W-1:0]            dl;
        logic [2:0][FAC_W-1:0]      a;
        logic [2:0][PHI_W-1:0]      fin;
        logic [2:0][QL_W-1:0]       th;
        logic [2:0][FACE_W-1:0]     face;
        logic [PHI_W-1:0]           phi;
    } t_ctx;

endpackage

/* sv/sdd_front.sv */
`timescale 1ns / 1ps
// coefficients, face terms, numerator and denominator in three stages
module sdd_front #(
    parameter int FRAC_BITS = sdd_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_vld,
    input  logic                           i_fixen,
    input  logic [sdd_pkg::FAC_W-1:0]      i_x_factor,
    input  logic [sdd_pkg::FAC_W-1:0]      i_y_factor,
    input  logic [sdd_pkg::FAC_W-1:0]      i_z_factor,
    input  logic [sdd_pkg::PHI_W-1:0]      i_src,
    input  logic [2:0][sdd_pkg::PHI_W-1:0] i_fin,
    input  logic [2:0][sdd_pkg::COS_W-1:0] i_cos,
    input  logic [sdd_pkg::FAC_W-1:0]      i_total,
    output logic                           o_vld,
    output sdd_pkg::t_ctx                  o_ctx
);
    localparam int P1_W = sdd_pkg::COS_W + sdd_pkg::FAC_W;

    // stage 1
    logic                               r_v1;
    logic                               r_fixen1;
    logic [sdd_pkg::PHI_W-1:0]          r_src1;
    logic [sdd_pkg::FAC_W-1:0]          r_total1;
    logic [2:0][sdd_pkg::PHI_W-1:0]     r_fin1;
    logic [2:0][P1_W-1:0]               r_p1;
    // stage 2
    logic                               r_v2;
    logic                               r_fixen2;
    logic [sdd_pkg::PHI_W-1:0]          r_src2;
    logic [sdd_pkg::FAC_W-1:0]          r_total2;
    logic [2:0][sdd_pkg::PHI_W-1:0]     r_fin2;
    logic [2:0][sdd_pkg::FAC_W-1:0]     r_a2;
    logic [2:0][sdd_pkg::QL_W-1:0]      r_prod2;
    // stage 3
    logic                               r_v3;
    sdd_pkg::t_ctx                      r_ctx3;

    logic [2:0][sdd_pkg::FAC_W-1:0]     n_a;
    logic [2:0][sdd_pkg::QL_W-1:0]      n_prod;
    sdd_pkg::t_ctx                      n_ctx;

    always_comb begin
        logic [P1_W-1:0] ps;
        for (int d = 0; d < 3; d++) begin
            ps = r_p1[d] >> FRAC_BITS;
            n_a[d] = (|ps[P1_W-1:sdd_pkg::FAC_W]) ? {sdd_pkg::FAC_W{1'b1}}
                                                   : ps[sdd_pkg::FAC_W-1:0];
            n_prod[d] = sdd_pkg::QL_W'($signed({1'b0, n_a[d]}) * $signed(r_fin1[d]));
        end
    end

    always_comb begin
        logic [sdd_pkg::QL_W-1:0] ql;
        logic [sdd_pkg::DL_W-1:0] dl;
        ql = {{(sdd_pkg::QL_W-sdd_pkg::PHI_W){r_src2[sdd_pkg::PHI_W-1]}}, r_src2};
        dl = sdd_pkg::DL_W'(r_total2);
        n_ctx = '0;
        for (int d = 0; d < 3; d++) begin
            ql = ql + sdd_pkg::QL_W'($signed(r_prod2[d]) >>> FRAC_BITS);
            dl = dl + sdd_pkg::DL_W'(r_a2[d]);
            n_ctx.th[d] = sdd_pkg::QL_W'($signed(r_prod2[d]) >>> (FRAC_BITS + 1));
        end
        n_ctx.need_div = 1'b1;
        n_ctx.fixen    = r_fixen2;
        n_ctx.ql       = ql;
        n_ctx.dl       = dl;
        n_ctx.a        = r_a2;
        n_ctx.fin      = r_fin2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fixen1 <= i_fixen;
            r_src1   <= i_src;
            r_total1 <= i_total;
            r_fin1   <= i_fin;
            r_p1[0]  <= P1_W'(i_cos[0] * i_x_factor);
            r_p1[1]  <= P1_W'(i_cos[1] * i_y_factor);
            r_p1[2]  <= P1_W'(i_cos[2] * i_z_factor);
            r_fixen2 <= r_fixen1;
            r_src2   <= r_src1;
            r_total2 <= r_total1;
            r_fin2   <= r_fin1;
            r_a2     <= n_a;
            r_prod2  <= n_prod;
            r_ctx3   <= n_ctx;
        end
    end

    assign o_vld = r_v3;
    assign o_ctx = r_ctx3;
endmodule

/* sv/sdd_div.sv */
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, cell flux = ql * 2^F / dl
module sdd_div #(
    parameter int FRAC_BITS = sdd_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  sdd_pkg::t_ctx i_ctx,
    output logic          o_vld,
    output sdd_pkg::t_ctx o_ctx
);
    localparam int STEPS = sdd_pkg::PHI_W;
    localparam int SH    = sdd_pkg::PHI_W - FRAC_BITS;
    localparam int DW    = sdd_pkg::DL_W;

    logic                  r_vld  [0:STEPS];
    sdd_pkg::t_ctx         r_ctx  [0:STEPS];
    logic [DW-1:0]         r_rem  [0:STEPS];
    logic [STEPS-1:0]      r_lo   [0:STEPS];
    logic [STEPS-1:0]      r_q    [0:STEPS];
    logic                  r_neg  [0:STEPS];
    logic                  r_zero [0:STEPS];
    logic                  r_ovf  [0:STEPS];
    logic                  r_ovld;
    sdd_pkg::t_ctx         r_octx;

    logic [sdd_pkg::QL_W-1:0] n_m;
    logic [sdd_pkg::QL_W-1:0] n_r0;
    logic                     n_ovf;
    sdd_pkg::t_ctx            n_octx;

    // magnitude and the high part of the shifted dividend; overflow if it reaches dl
    always_comb begin
        n_m   = i_ctx.ql[sdd_pkg::QL_W-1] ? (~i_ctx.ql + 1'b1) : i_ctx.ql;
        n_r0  = n_m >> SH;
        n_ovf = n_r0 >= sdd_pkg::QL_W'(i_ctx.dl);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx[0]  <= i_ctx;
            r_rem[0]  <= n_ovf ? '0 : n_r0[DW-1:0];
            r_lo[0]   <= n_m[STEPS-1:0] << FRAC_BITS;
            r_q[0]    <= '0;
            r_neg[0]  <= i_ctx.ql[sdd_pkg::QL_W-1];
            r_zero[0] <= (n_m == '0);
            r_ovf[0]  <= n_ovf;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [DW:0]   t;
        logic          ge;
        logic [DW:0]   diff;
        assign t    = {r_rem[k], r_lo[k][STEPS-1]};
        assign diff = t - {1'b0, r_ctx[k].dl};
        assign ge   = t >= {1'b0, r_ctx[k].dl};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctx[k+1]  <= r_ctx[k];
                r_rem[k+1]  <= ge ? diff[DW-1:0] : t[DW-1:0];
                r_lo[k+1]   <= r_lo[k] << 1;
                r_q[k+1]    <= {r_q[k][STEPS-2:0], ge};
                r_neg[k+1]  <= r_neg[k];
                r_zero[k+1] <= r_zero[k];
                r_ovf[k+1]  <= r_ovf[k];
            end
        end
    end

    // sign and saturation
    always_comb begin
        logic [STEPS-1:0] q;
        q = r_q[STEPS];
        n_octx = r_ctx[STEPS];
        if (r_ctx[STEPS].div) begin
            if (r_zero[STEPS]) begin
                n_octx.phi = '0;
            end else if (r_ovf[STEPS]) begin
                n_octx.phi = r_neg[STEPS] ? sdd_pkg::S32_MIN : sdd_pkg::S32_MAX;
            end else if (r_neg[STEPS]) begin
                n_octx.phi = q[STEPS-1] ? sdd_pkg::S32_MIN : (~q + 1'b1);
            end else begin
                n_octx.phi = q[STEPS-1] ? sdd_pkg::S32_MAX : q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_ovld <= r_vld[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_octx <= n_octx;
        end
    end

    assign o_vld = r_ovld;
    assign o_ctx = r_octx;
endmodule

/* sv/sdd_pass.sv */
`timescale 1ns / 1ps
// one solve pass: pick the face to fix, divide, recompute the open faces
module sdd_pass #(
    parameter int FRAC_BITS = sdd_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  sdd_pkg::t_ctx i_ctx,
    output logic          o_vld,
    output sdd_pkg::t_ctx o_ctx
);
    logic          r_hvld;
    sdd_pkg::t_ctx r_hctx;
    logic          w_dvld;
    sdd_pkg::t_ctx w_dctx;
    logic          r_fvld;
    sdd_pkg::t_ctx r_fctx;
    sdd_pkg::t_ctx n_hctx;
    sdd_pkg::t_ctx n_fctx;

    // first negative open face in x, y, z order
    always_comb begin
        logic [2:0] neg;
        logic [2:0] hit;
        for (int d = 0; d < 3; d++) begin
            neg[d] = !i_ctx.fixed[d] && i_ctx.face[d][sdd_pkg::FACE_W-1];
        end
        hit[0] = neg[0];
        hit[1] = neg[1] && !neg[0];
        hit[2] = neg[2] && !neg[1] && !neg[0];
        n_hctx = i_ctx;
        n_hctx.div = 1'b0;
        if (i_ctx.need_div) begin
            n_hctx.div = 1'b1;
        end else if (i_ctx.fixen && (|neg)) begin
            n_hctx.div = 1'b1;
            for (int d = 0; d < 3; d++) begin
                if (hit[d]) begin
                    n_hctx.ql       = i_ctx.ql - i_ctx.th[d];
                    n_hctx.dl       = i_ctx.dl - sdd_pkg::DL_W'(i_ctx.a[d]);
                    n_hctx.fixed[d] = 1'b1;
                    n_hctx.face[d]  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvld <= 1'b0;
            r_fvld <= 1'b0;
        end else if (i_en) begin
            r_hvld <= i_vld;
            r_fvld <= w_dvld;
        end
    end

    sdd_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (i_en),
        .i_vld  (r_hvld),
        .i_ctx  (r_hctx),
        .o_vld  (w_dvld),
        .o_ctx  (w_dctx)
    );

    // outgoing face = 2 * phi - incoming, kept wide
    always_comb begin
        logic [sdd_pkg::FACE_W-1:0] phi_x2;
        phi_x2 = {w_dctx.phi[sdd_pkg::PHI_W-1], w_dctx.phi, 1'b0};
        n_fctx = w_dctx;
        n_fctx.need_div = 1'b0;
        if (w_dctx.div) begin
            for (int d = 0; d < 3; d++) begin
                if (!w_dctx.fixed[d]) begin
                    n_fctx.face[d] = phi_x2 - {{(sdd_pkg::FACE_W-sdd_pkg::PHI_W)
                                     {w_dctx.fin[d][sdd_pkg::PHI_W-1]}}, w_dctx.fin[d]};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hctx <= n_hctx;
            r_fctx <= n_fctx;
        end
    end

    assign o_vld = r_fvld;
    assign o_ctx = r_fctx;
endmodule

/* sv/sn_diamond_difference_cell_solve.sv */
`timescale 1ns / 1ps
// Diamond-difference cell solver with set-to-zero fixup, top level.
// Input channel i_valid / o_ready carries one cell; output channel o_valid /
// i_ready returns cell flux and three outgoing face fluxes, one per cell.
// From input accept to output valid a cell passes three front stages
// (coefficient multiply, face-term multiply, sums), then four solve passes of
// 36 stages each (select, 34-stage divider, face update), then one output
// register. The divider, one quotient bit per stage, sets the depth.
// One cell per cycle when not stalled; unused fixup passes are carried through.
// The whole pipe moves on one enable: while the output holds an unaccepted
// result, o_ready is low and every stage holds, so nothing is lost or repeated.
// Configuration (i_cfg_we, i_cfg_index, i_cfg_data) writes take effect at once
// and should only be issued while the pipe is empty; fixup enable is sampled
// with each cell as it enters.
// Reset (synchronous, active low) empties the pipe, clears fixup enable and
// sets the three face factors to 2.0.
module sn_diamond_difference_cell_solve #(
    parameter int FRAC_BITS = sdd_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [sdd_pkg::PHI_W-1:0] i_cell_source,
    input  logic signed [sdd_pkg::PHI_W-1:0] i_in_x_flux,
    input  logic signed [sdd_pkg::PHI_W-1:0] i_in_y_flux,
    input  logic signed [sdd_pkg::PHI_W-1:0] i_in_z_flux,
    input  logic [sdd_pkg::COS_W-1:0]        i_cos_x,
    input  logic [sdd_pkg::COS_W-1:0]        i_cos_y,
    input  logic [sdd_pkg::COS_W-1:0]        i_cos_z,
    input  logic [sdd_pkg::FAC_W-1:0]        i_total_xs,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [sdd_pkg::PHI_W-1:0] o_cell_flux,
    output logic signed [sdd_pkg::PHI_W-1:0] o_out_x_flux,
    output logic signed [sdd_pkg::PHI_W-1:0] o_out_y_flux,
    output logic signed [sdd_pkg::PHI_W-1:0] o_out_z_flux,
    input  logic                             i_cfg_we,
    input  logic [sdd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sdd_pkg::FAC_W-1:0]        i_cfg_data
);
    localparam int NPASS = 4;

    logic                          r_fixen;
    logic [sdd_pkg::FAC_W-1:0]     r_x_factor;
    logic [sdd_pkg::FAC_W-1:0]     r_y_factor;
    logic [sdd_pkg::FAC_W-1:0]     r_z_factor;

    logic                          w_en;
    logic                          w_vld [0:NPASS];
    sdd_pkg::t_ctx                 w_ctx [0:NPASS];

    logic                          r_ovld;
    logic [sdd_pkg::PHI_W-1:0]     r_ophi;
    logic [2:0][sdd_pkg::PHI_W-1:0] r_oface;
    logic [2:0]                    r_ofixed;
    logic                          r_ofixen;
    logic [2:0]                    r_oneg;
    logic [2:0][sdd_pkg::PHI_W-1:0] n_oface;
    logic [2:0]                    n_oneg;

    assign w_en    = !r_ovld || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixen    <= 1'b0;
            r_x_factor <= sdd_pkg::FACTOR_RST;
            r_y_factor <= sdd_pkg::FACTOR_RST;
            r_z_factor <= sdd_pkg::FACTOR_RST;
        end else if (i_cfg_we) begin
            case (sdd_pkg::t_cfg_idx'(i_cfg_index))
                sdd_pkg::CFG_FIXUP:    r_fixen    <= i_cfg_data[0];
                sdd_pkg::CFG_X_FACTOR: r_x_factor <= i_cfg_data;
                sdd_pkg::CFG_Y_FACTOR: r_y_factor <= i_cfg_data;
                sdd_pkg::CFG_Z_FACTOR: r_z_factor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sdd_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_vld     (i_valid),
        .i_fixen   (r_fixen),
        .i_x_factor(r_x_factor),
        .i_y_factor(r_y_factor),
        .i_z_factor(r_z_factor),
        .i_src     (i_cell_source),
        .i_fin     ({i_in_z_flux, i_in_y_flux, i_in_x_flux}),
        .i_cos     ({i_cos_z, i_cos_y, i_cos_x}),
        .i_total   (i_total_xs),
        .o_vld     (w_vld[0]),
        .o_ctx     (w_ctx[0])
    );

    // first pass always divides; the other three apply at most one fixup each
    for (genvar p = 0; p < NPASS; p++) begin : g_pass
        sdd_pass #(
            .FRAC_BITS(FRAC_BITS)
        ) u_pass (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_vld  (w_vld[p]),
            .i_ctx  (w_ctx[p]),
            .o_vld  (w_vld[p+1]),
            .o_ctx  (w_ctx[p+1])
        );
    end

    always_comb begin
        logic [sdd_pkg::FACE_W-1:0] f;
        for (int d = 0; d < 3; d++) begin
            f = w_ctx[NPASS].face[d];
            n_oneg[d] = f[sdd_pkg::FACE_W-1];
            if ((&f[sdd_pkg::FACE_W-1:sdd_pkg::PHI_W-1])
                    || !(|f[sdd_pkg::FACE_W-1:sdd_pkg::PHI_W-1])) begin
                n_oface[d] = f[sdd_pkg::PHI_W-1:0];
            end else begin
                n_oface[d] = f[sdd_pkg::FACE_W-1] ? sdd_pkg::S32_MIN : sdd_pkg::S32_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= w_vld[NPASS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ophi   <= w_ctx[NPASS].phi;
            r_oface  <= n_oface;
            r_ofixed <= w_ctx[NPASS].fixed;
            r_ofixen <= w_ctx[NPASS].fixen;
            r_oneg   <= n_oneg;
        end
    end

    assign o_valid      = r_ovld;
    assign o_cell_flux  = r_ophi;
    assign o_out_x_flux = r_oface[0];
    assign o_out_y_flux = r_oface[1];
    assign o_out_z_flux = r_oface[2];

`ifndef SYNTHESIS
    // no fixup may happen with fixup disabled
    a_no_fix_when_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !r_ofixen) |-> (r_ofixed == 3'b000))
        else $error("face fixed with fixup disabled");

    // a fixed face leaves as exactly zero
    a_fixed_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> ((!r_ofixed[0] || o_out_x_flux == '0)
                 && (!r_ofixed[1] || o_out_y_flux == '0)
                 && (!r_ofixed[2] || o_out_z_flux == '0)))
        else $error("fixed face not zero");

    // with fixup on, no open face may leave negative
    a_fixup_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_ofixen) |-> ((r_oneg & ~r_ofixed) == 3'b000))
        else $error("negative face left after fixup");

    // pipe is empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid after reset");
`endif
endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench of the diamond-difference cell solver
module tb;

    localparam int FB = 16;
    localparam int PIPE_LAT = 148;

    typedef struct packed {
        logic signed [31:0] src;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        logic [16:0]        cx;
        logic [16:0]        cy;
        logic [16:0]        cz;
        logic [30:0]        sig;
    } t_cell;

    typedef struct packed {
        logic signed [31:0] phi;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
    } t_flux;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic signed [31:0] i_cell_source, i_in_x_flux, i_in_y_flux, i_in_z_flux;
    logic [16:0] i_cos_x, i_cos_y, i_cos_z;
    logic [30:0] i_total_xs;
    logic        o_valid;
    logic        i_ready;
    logic signed [31:0] o_cell_flux, o_out_x_flux, o_out_y_flux, o_out_z_flux;
    logic        i_cfg_we;
    logic [sdd_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [sdd_pkg::FAC_W-1:0]     i_cfg_data;

    sn_diamond_difference_cell_solve DUT (.*);

    // predictor copy of the registers
    logic        fix_on;
    logic [30:0] face_fac [3];

    t_cell pending_cells[$];
    t_flux expected_flux[$];
    int    n_errors;
    bit    calm;        // no idling on either side
    bit    in_taken;    // input item accepted at the last rising edge

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint cell_quotient(longint ql, longint dl);
        logic [63:0] m, d, iq, rem, mag;
        bit neg;
        neg = ql < 0;
        m = neg ? -ql : ql;
        if (dl <= 0) begin
            if (ql > 0) return 64'sd2147483647;
            if (ql < 0) return -64'sd2147483648;
            return 0;
        end
        d = dl;
        iq = m / d;
        rem = m % d;
        if (iq >= 64'h8000_0000) return neg ? -64'sd2147483648 : 64'sd2147483647;
        mag = (iq << FB) + (rem << FB) / d;
        if (neg) return mag > 64'h8000_0000 ? -64'sd2147483648 : -longint'(mag);
        return mag > 64'h7fff_ffff ? 64'sd2147483647 : longint'(mag);
    endfunction

    function automatic t_flux solve_cell(t_cell c);
        longint fin[3], a[3], prod[3], face[3];
        logic [16:0] cs[3];
        bit fixed[3];
        longint ql, dl, phi, p;
        int hit;
        t_flux r;
        fin[0] = c.fx; fin[1] = c.fy; fin[2] = c.fz;
        cs[0] = c.cx; cs[1] = c.cy; cs[2] = c.cz;
        ql = c.src;
        dl = c.sig;
        for (int d = 0; d < 3; d++) begin
            p = (longint'(cs[d]) * longint'(face_fac[d])) >>> FB;
            a[d] = p > 64'sd2147483647 ? 64'sd2147483647 : p;
            prod[d] = a[d] * fin[d];
            ql += floor_sh(prod[d], FB);
            dl += a[d];
            fixed[d] = 0;
        end
        phi = cell_quotient(ql, dl);
        for (int d = 0; d < 3; d++) face[d] = 2 * phi - fin[d];
        if (fix_on) begin
            for (int pass = 0; pass < 3; pass++) begin
                hit = -1;
                for (int d = 2; d >= 0; d--)
                    if (!fixed[d] && face[d] < 0) hit = d;
                if (hit >= 0) begin
                    ql -= floor_sh(prod[hit], FB + 1);
                    dl -= a[hit];
                    fixed[hit] = 1;
                    face[hit] = 0;
                    phi = cell_quotient(ql, dl);
                    for (int d = 0; d < 3; d++)
                        if (!fixed[d]) face[d] = 2 * phi - fin[d];
                end
            end
        end
        r.phi = phi[31:0];
        r.ox = 32'(clamp32(face[0]));
        r.oy = 32'(clamp32(face[1]));
        r.oz = 32'(clamp32(face[2]));
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            // previous item taken at the last rising edge (or none held)
            if (in_taken) void'(pending_cells.pop_front());
            if (pending_cells.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
                {i_cell_source, i_in_x_flux, i_in_y_flux, i_in_z_flux,
                 i_cos_x, i_cos_y, i_cos_z, i_total_xs} <= pending_cells[0];
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // the predictor runs at acceptance, with the registers then in force
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready)
            expected_flux.push_back(solve_cell({i_cell_source, i_in_x_flux,
                i_in_y_flux, i_in_z_flux, i_cos_x, i_cos_y, i_cos_z, i_total_xs}));
    end

    always @(negedge i_clk) begin
        i_ready <= !i_rst_n ? 1'b0 : (calm || $urandom_range(99) >= 30);
    end

    // monitor
    always @(posedge i_clk) begin
        t_flux w;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_flux.size() == 0) begin
                $display("result with no item outstanding");
                n_errors++;
            end else begin
                w = expected_flux.pop_front();
                if (o_cell_flux !== w.phi) report("cell_flux", o_cell_flux, w.phi);
                if (o_out_x_flux !== w.ox) report("out_x_flux", o_out_x_flux, w.ox);
                if (o_out_y_flux !== w.oy) report("out_y_flux", o_out_y_flux, w.oy);
                if (o_out_z_flux !== w.oz) report("out_z_flux", o_out_z_flux, w.oz);
            end
        end
    end

    task automatic write_reg(sdd_pkg::t_cfg_idx idx, logic [30:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            sdd_pkg::CFG_FIXUP:    fix_on <= val[0];
            sdd_pkg::CFG_X_FACTOR: face_fac[0] <= val;
            sdd_pkg::CFG_Y_FACTOR: face_fac[1] <= val;
            default:               face_fac[2] <= val;
        endcase
    endtask

    task automatic drain();
        wait (pending_cells.size() == 0 && !i_valid);
        wait (expected_flux.size() == 0);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_flux();
        case ($urandom_range(5))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            3:       return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [16:0] rand_cos();
        case ($urandom_range(7))
            0:       return 17'd0;
            1:       return 17'd65536;
            2:       return 17'h1ffff;
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    function automatic t_cell rand_cell();
        t_cell c;
        c.src = rand_flux();
        c.fx = rand_flux();
        c.fy = rand_flux();
        c.fz = rand_flux();
        c.cx = rand_cos();
        c.cy = rand_cos();
        c.cz = rand_cos();
        case ($urandom_range(4))
            0:       c.sig = 31'd0;
            1:       c.sig = 31'h7fff_ffff;
            2:       c.sig = 31'($urandom);
            default: c.sig = 31'($urandom_range(32'h0008_0000));
        endcase
        return c;
    endfunction

    function automatic t_cell mk(int src, int fx, int fy, int fz,
                                 int cx, int cy, int cz, int sig);
        t_cell c;
        c = {src, fx, fy, fz, cx[16:0], cy[16:0], cz[16:0], sig[30:0]};
        return c;
    endfunction

    task automatic directed_set();
        pending_cells.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));                  // zero over zero
        pending_cells.push_back(mk(65536, 0, 0, 0, 0, 0, 0, 0));              // positive over zero
        pending_cells.push_back(mk(-65536, 0, 0, 0, 0, 0, 0, 0));             // negative over zero
        pending_cells.push_back(mk(65536, 65536, 65536, 65536, 37837, 37837, 37837, 65536));
        pending_cells.push_back(mk(0, 655360, 0, 0, 65536, 0, 0, 65536));     // x inflow, no face negative
        pending_cells.push_back(mk(0, 655360, 655360, 0, 65536, 65536, 0, 6553));
        pending_cells.push_back(mk(0, 655360, 655360, 655360, 65536, 65536, 65536, 0));
        pending_cells.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                   65536, 65536, 65536, 1));
        pending_cells.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                                   65536, 65536, 65536, 1));
        pending_cells.push_back(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                                   17'h1ffff, 17'h1ffff, 17'h1ffff, 32'h7fffffff));
        pending_cells.push_back(mk(-1, -1, -1, -1, 1, 1, 1, 1));
        pending_cells.push_back(mk(32'h7fffffff, 0, 0, 0, 0, 0, 0, 1));        // quotient saturates
        pending_cells.push_back(mk(0, 0, 0, 0, 0, 0, 0, 32'h7fffffff));
        pending_cells.push_back(mk(65536, -655360, 0, 0, 65536, 65536, 0, 131072));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = sdd_pkg::CFG_FIXUP;
        i_cfg_data = '0;
        {i_cell_source, i_in_x_flux, i_in_y_flux, i_in_z_flux} = '0;
        {i_cos_x, i_cos_y, i_cos_z, i_total_xs} = '0;
        n_errors = 0;
        calm = 0;
        fix_on = 1'b0;
        face_fac[0] = sdd_pkg::FACTOR_RST;
        face_fac[1] = sdd_pkg::FACTOR_RST;
        face_fac[2] = sdd_pkg::FACTOR_RST;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, then fixup on with the same directed cells
        directed_set();
        drain();
        write_reg(sdd_pkg::CFG_FIXUP, 31'd1);
        directed_set();
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(sdd_pkg::CFG_FIXUP, ph[0] ? 31'd0 : 31'd1);
            for (int d = 0; d < 3; d++) begin
                logic [30:0] f;
                case ((ph + d) % 4)
                    0:       f = 31'd0;
                    1:       f = 31'h7fff_ffff;
                    2:       f = 31'($urandom_range(32'h0004_0000));
                    default: f = 31'($urandom);
                endcase
                if (ph == 5) f = sdd_pkg::FACTOR_RST;
                write_reg(sdd_pkg::t_cfg_idx'(d + 1), f);
            end
            calm = (ph == 3);
            for (int n = 0; n < 80; n++) pending_cells.push_back(rand_cell());
            drain();
        end

        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
